### design/lpom_pkg.sv
// package: shared constants, sine table, state type and helper functions
`timescale 1ns / 1ps

package lpom_pkg;

    localparam int MAP_SIDE_DEF = 1024;
    localparam int WORD_BITS    = 32;
    localparam int BIT_IDX_W    = 5;

    localparam int MODE_W   = 2;
    localparam int POSE_W   = 10;
    localparam int HEAD_W   = 9;
    localparam int POINT_W  = 11;
    localparam int TRIG_W   = 16;
    localparam int FRAC_W   = 14;
    localparam int PROD_W   = POINT_W + TRIG_W;
    localparam int TRUNC_W  = PROD_W - FRAC_W;
    localparam int DEG_W    = 10;

    localparam logic [DEG_W-1:0] HALF_TURN_DEG    = 10'd180;
    localparam logic [DEG_W-1:0] FULL_TURN_DEG    = 10'd360;
    localparam logic [DEG_W-1:0] QUARTER_TURN_DEG = 10'd90;

    localparam logic [MODE_W-1:0] MODE_POSE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ADR,
        S_RD,
        S_WB
    } t_state;

    // round(16384 * sin(k deg)), k = 0..90
    localparam logic [14:0] QSINE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11983, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // sine in q1.14 of a degree value 0..449
    function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0]         d;
        logic                     neg;
        logic signed [TRIG_W-1:0] mag;
        begin
            d = deg;
            if (d >= FULL_TURN_DEG) begin
                d = d - FULL_TURN_DEG;
            end
            neg = (d >= HALF_TURN_DEG);
            if (neg) begin
                d = d - HALF_TURN_DEG;
            end
            if (d > QUARTER_TURN_DEG) begin
                d = HALF_TURN_DEG - d;
            end
            mag = $signed({1'b0, QSINE[d[6:0]]});
            return neg ? -mag : mag;
        end
    endfunction

    // product scaled down by 2^14, truncated toward zero
    function automatic logic signed [TRUNC_W-1:0] trunc_q14(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        begin
            adj = p + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{p[PROD_W-1]}}});
            return adj[PROD_W-1:FRAC_W];
        end
    endfunction

endpackage

### design/lidar_point_occupancy_marker_top.sv
// top level: pose registers, sequencer, map memory read-modify-write, result register
//
// A mark or read beat runs alone through multiply, sum, address, memory read
// and write-back before the next beat is taken; a pose beat or a beat of the
// unused mode goes straight to write-back. A result held at the output stalls
// the write-back, and no input beat is taken until that result leaves. The
// per-beat cost is set by the transform stages followed by the registered read
// of the map memory. After reset the map memory is cleared one word a cycle,
// all MAP_SIDE*MAP_SIDE/32 words (32768 words at the default size), and no
// input beat is taken meanwhile.
// An out-of-map point is not written and answers cell_bit 0, in_map 0.
`timescale 1ns / 1ps

module lidar_point_occupancy_marker_top #(
    parameter int MAP_SIDE = lpom_pkg::MAP_SIDE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [lpom_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [lpom_pkg::POSE_W-1:0]   i_pose_x,
    input  logic signed [lpom_pkg::POSE_W-1:0]   i_pose_y,
    input  logic [lpom_pkg::HEAD_W-1:0]          i_heading_deg,
    input  logic signed [lpom_pkg::POINT_W-1:0]  i_point_x,
    input  logic signed [lpom_pkg::POINT_W-1:0]  i_point_y,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_cell_bit,
    output logic                                 o_in_map
);

    localparam int DEPTH  = (MAP_SIDE * MAP_SIDE + lpom_pkg::WORD_BITS - 1)
                            / lpom_pkg::WORD_BITS;
    localparam int ADDR_W = $clog2(DEPTH);

    lpom_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0]                     r_clr_addr;
    logic [lpom_pkg::MODE_W-1:0]           r_mode;
    logic signed [lpom_pkg::POINT_W-1:0]   r_px, r_py;
    logic signed [lpom_pkg::POSE_W-1:0]    r_pose_col, r_pose_row;
    logic signed [lpom_pkg::TRIG_W-1:0]    r_sin, r_cos;
    logic                                  r_out_valid, r_cell_bit, r_in_map;

    logic [lpom_pkg::HEAD_W-1:0]           head_red;
    logic [ADDR_W-1:0]                     x_waddr;
    logic [lpom_pkg::BIT_IDX_W-1:0]        x_bit;
    logic                                  x_inside;
    logic [lpom_pkg::WORD_BITS-1:0]        rdata, wdata;
    logic [ADDR_W-1:0]                     waddr;
    logic                                  accept, out_free, wb_fire, mem_we, mem_re;
    logic                                  is_mark, is_read;

    assign is_mark  = (r_mode == lpom_pkg::MODE_MARK);
    assign is_read  = (r_mode == lpom_pkg::MODE_READ);
    assign out_free = !r_out_valid || i_ready;
    assign head_red = (i_heading_deg >= lpom_pkg::HEAD_W'(lpom_pkg::FULL_TURN_DEG))
                    ? i_heading_deg - lpom_pkg::HEAD_W'(lpom_pkg::FULL_TURN_DEG)
                    : i_heading_deg;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpom_pkg::S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = lpom_pkg::S_IDLE;
            end
            lpom_pkg::S_IDLE: begin
                if (i_valid) begin
                    if ((i_mode == lpom_pkg::MODE_MARK) || (i_mode == lpom_pkg::MODE_READ)) begin
                        n_state = lpom_pkg::S_MUL;
                    end else begin
                        n_state = lpom_pkg::S_WB;
                    end
                end
            end
            lpom_pkg::S_MUL: n_state = lpom_pkg::S_SUM;
            lpom_pkg::S_SUM: n_state = lpom_pkg::S_ADR;
            lpom_pkg::S_ADR: n_state = lpom_pkg::S_RD;
            lpom_pkg::S_RD:  n_state = lpom_pkg::S_WB;
            lpom_pkg::S_WB: begin
                if (out_free) n_state = lpom_pkg::S_IDLE;
            end
            default: n_state = lpom_pkg::S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready = 1'b0;
        mem_re  = 1'b0;
        wb_fire = 1'b0;
        unique case (r_state)
            lpom_pkg::S_IDLE: o_ready = 1'b1;
            lpom_pkg::S_RD:   mem_re  = 1'b1;
            lpom_pkg::S_WB:   wb_fire = out_free;
            default: ;
        endcase
    end

    assign accept = i_valid && o_ready;
    assign mem_we = (r_state == lpom_pkg::S_CLEAR) || (wb_fire && is_mark && x_inside);
    assign waddr  = (r_state == lpom_pkg::S_CLEAR) ? r_clr_addr : x_waddr;
    assign wdata  = (r_state == lpom_pkg::S_CLEAR) ? '0
                  : (rdata | (lpom_pkg::WORD_BITS'(1) << x_bit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lpom_pkg::S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lpom_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // pose and heading trig
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_col <= '0;
            r_pose_row <= '0;
            r_sin      <= '0;
            r_cos      <= lpom_pkg::TRIG_ONE;
        end else if (accept && (i_mode == lpom_pkg::MODE_POSE)) begin
            r_pose_col <= i_pose_x;
            r_pose_row <= i_pose_y;
            r_sin      <= lpom_pkg::sine_q14(lpom_pkg::DEG_W'(head_red));
            r_cos      <= lpom_pkg::sine_q14(lpom_pkg::DEG_W'(head_red)
                                             + lpom_pkg::QUARTER_TURN_DEG);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            r_in_map   <= (is_mark || is_read) && x_inside;
            r_cell_bit <= x_inside && (is_mark || (is_read && rdata[x_bit]));
        end
    end

    assign o_valid    = r_out_valid;
    assign o_cell_bit = r_cell_bit;
    assign o_in_map   = r_in_map;

    lpom_xform #(
        .MAP_SIDE (MAP_SIDE),
        .ADDR_W   (ADDR_W)
    ) u_xform (
        .i_clk      (i_clk),
        .i_px       (r_px),
        .i_py       (r_py),
        .i_sin      (r_sin),
        .i_cos      (r_cos),
        .i_pose_col (r_pose_col),
        .i_pose_row (r_pose_row),
        .i_direct   (is_read),
        .o_waddr    (x_waddr),
        .o_bit      (x_bit),
        .o_inside   (x_inside)
    );

    lpom_map_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (mem_re),
        .i_raddr (x_waddr),
        .o_rdata (rdata)
    );

endmodule

### design/lpom_map_ram.sv
// map word memory: one write port, one registered read port
`timescale 1ns / 1ps

module lpom_map_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [ADDR_W-1:0]              i_waddr,
    input  logic [lpom_pkg::WORD_BITS-1:0] i_wdata,
    input  logic                           i_re,
    input  logic [ADDR_W-1:0]              i_raddr,
    output logic [lpom_pkg::WORD_BITS-1:0] o_rdata
);

    logic [lpom_pkg::WORD_BITS-1:0] r_mem [0:DEPTH-1];
    logic [lpom_pkg::WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/lpom_xform.sv
// point transform: rotate products, offset sums, bounds test, word address
`timescale 1ns / 1ps

module lpom_xform #(
    parameter int MAP_SIDE = 1024,
    parameter int ADDR_W   = 15
) (
    input  logic                                  i_clk,
    input  logic signed [lpom_pkg::POINT_W-1:0]   i_px,
    input  logic signed [lpom_pkg::POINT_W-1:0]   i_py,
    input  logic signed [lpom_pkg::TRIG_W-1:0]    i_sin,
    input  logic signed [lpom_pkg::TRIG_W-1:0]    i_cos,
    input  logic signed [lpom_pkg::POSE_W-1:0]    i_pose_col,
    input  logic signed [lpom_pkg::POSE_W-1:0]    i_pose_row,
    input  logic                                  i_direct,
    output logic [ADDR_W-1:0]                     o_waddr,
    output logic [lpom_pkg::BIT_IDX_W-1:0]        o_bit,
    output logic                                  o_inside
);

    localparam int CLW  = $clog2(MAP_SIDE);
    localparam int COLW = CLW + 1;
    localparam int CW   = ((COLW > 12) ? COLW : 12) + 2;
    localparam int NW   = $clog2(MAP_SIDE * MAP_SIDE);
    localparam logic signed [CW-1:0] HALF_C = CW'(MAP_SIDE / 2);
    localparam logic signed [CW-1:0] SIDE_C = CW'(MAP_SIDE);

    logic signed [lpom_pkg::TRUNC_W-1:0] r_t_xc, r_t_ys, r_t_yc, r_t_xs;
    logic signed [CW-1:0] col_sum, row_sum, col_sel, row_sel;
    logic [CLW-1:0] r_col, r_row;
    logic           r_inside;
    logic [NW-1:0]  cell_n;
    logic [ADDR_W-1:0]               r_waddr;
    logic [lpom_pkg::BIT_IDX_W-1:0]  r_bit;
    logic                            r_inside_q;

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_t_xc <= lpom_pkg::trunc_q14(lpom_pkg::PROD_W'(i_px * i_cos));
        r_t_ys <= lpom_pkg::trunc_q14(lpom_pkg::PROD_W'(i_py * i_sin));
        r_t_yc <= lpom_pkg::trunc_q14(lpom_pkg::PROD_W'(i_py * i_cos));
        r_t_xs <= lpom_pkg::trunc_q14(lpom_pkg::PROD_W'(i_px * i_sin));
    end

    // sum and bounds stage
    always_comb begin
        col_sum = HALF_C + CW'(r_t_xc) + CW'(r_t_ys) + CW'(i_pose_col);
        row_sum = HALF_C + CW'(r_t_yc) - CW'(r_t_xs) - CW'(i_pose_row);
        col_sel = i_direct ? CW'(i_px) : col_sum;
        row_sel = i_direct ? CW'(i_py) : row_sum;
    end

    always_ff @(posedge i_clk) begin
        r_col    <= col_sel[CLW-1:0];
        r_row    <= row_sel[CLW-1:0];
        r_inside <= !col_sel[CW-1] && (col_sel < SIDE_C)
                 && !row_sel[CW-1] && (row_sel < SIDE_C);
    end

    // address stage
    assign cell_n = NW'(r_col) * NW'(MAP_SIDE) + NW'(r_row);

    always_ff @(posedge i_clk) begin
        r_waddr    <= ADDR_W'(cell_n >> lpom_pkg::BIT_IDX_W);
        r_bit      <= cell_n[lpom_pkg::BIT_IDX_W-1:0];
        r_inside_q <= r_inside;
    end

    assign o_waddr  = r_waddr;
    assign o_bit    = r_bit;
    assign o_inside = r_inside_q;

endmodule

### design/lpom_checker.sv
// port checker for the top level, with its bind
`timescale 1ns / 1ps

module lpom_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_cell_bit,
    input logic o_in_map
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable({o_cell_bit, o_in_map}))
        else $error("stalled result payload changed");

    a_bit_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cell_bit) |-> o_in_map)
        else $error("set cell bit outside the map");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second beat taken while one is in flight");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input taken during map clear");

endmodule

bind lidar_point_occupancy_marker_top lpom_checker u_lpom_checker (.*);

### tb/lidar_point_occupancy_marker_top_tb.sv
// testbench: occupancy marker beats checked against an in-bench pose and map predictor
`timescale 1ns / 1ps

module lidar_point_occupancy_marker_top_tb;

    localparam int MAP_N        = lpom_pkg::MAP_SIDE_DEF;
    localparam int DEG_FULL     = 360;
    localparam int DEG_HALF     = 180;
    localparam int DEG_QUARTER  = 90;
    localparam int Q14_ONE      = 16384;
    localparam int RANDOM_BEATS = 700;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT_BEAT = 120;
    localparam int BURST_FIRST  = 400;
    localparam int BURST_LAST   = 470;
    localparam int DRAIN_CYCLES = 24;
    localparam int SHOW_LIMIT   = 10;

    localparam logic [lpom_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [lpom_pkg::MODE_W-1:0]         mode;
        logic signed [lpom_pkg::POSE_W-1:0]  pose_x;
        logic signed [lpom_pkg::POSE_W-1:0]  pose_y;
        logic [lpom_pkg::HEAD_W-1:0]         heading_deg;
        logic signed [lpom_pkg::POINT_W-1:0] point_x;
        logic signed [lpom_pkg::POINT_W-1:0] point_y;
    } t_beat;

    typedef struct {
        bit cell_bit;
        bit in_map;
    } t_cell_answer;

    typedef struct {
        t_beat        beat;
        bit           typed;
        t_cell_answer answer;
    } t_dir_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic [lpom_pkg::MODE_W-1:0]         i_mode;
    logic signed [lpom_pkg::POSE_W-1:0]  i_pose_x;
    logic signed [lpom_pkg::POSE_W-1:0]  i_pose_y;
    logic [lpom_pkg::HEAD_W-1:0]         i_heading_deg;
    logic signed [lpom_pkg::POINT_W-1:0] i_point_x;
    logic signed [lpom_pkg::POINT_W-1:0] i_point_y;
    logic                                o_valid;
    logic                                i_ready;
    logic                                o_cell_bit;
    logic                                o_in_map;

    int sine_tab [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11983, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    int           pose_col;
    int           pose_row;
    int           head_now;
    bit           occ_cells [int];
    int           marked_cells [$];
    t_cell_answer cell_answers_q [$];
    t_dir_row     dir_tab [$];

    int  beats_sent;
    int  mismatches = 0;
    int  cycle_cnt = 0;
    bit  burst_phase;
    bit  hold_done;
    int  stall_left;

    lidar_point_occupancy_marker_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_pose_x      (i_pose_x),
        .i_pose_y      (i_pose_y),
        .i_heading_deg (i_heading_deg),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_bit    (o_cell_bit),
        .o_in_map      (o_in_map)
    );

    always #4 i_clk = ~i_clk;

    function automatic int sine_of(input int deg);
        int  d;
        bit  neg;
        d   = deg % DEG_FULL;
        neg = 1'b0;
        if (d >= DEG_HALF) begin
            d   = d - DEG_HALF;
            neg = 1'b1;
        end
        if (d > DEG_QUARTER) begin
            d = DEG_HALF - d;
        end
        return neg ? -sine_tab[d] : sine_tab[d];
    endfunction

    // integer division truncates toward zero
    function automatic longint scale_q14(input int a, input int b);
        longint p;
        p = longint'(a) * longint'(b);
        return p / Q14_ONE;
    endfunction

    function automatic bit on_map(input longint col, input longint row);
        return col >= 0 && col < MAP_N && row >= 0 && row < MAP_N;
    endfunction

    function automatic t_cell_answer occupancy_predict(input t_beat b);
        t_cell_answer a;
        int           px;
        int           py;
        int           s;
        int           c;
        int           h;
        int           n;
        longint       col;
        longint       row;
        a.cell_bit = 1'b0;
        a.in_map   = 1'b0;
        px = int'(b.point_x);
        py = int'(b.point_y);
        case (b.mode)
            lpom_pkg::MODE_POSE: begin
                pose_col = int'(b.pose_x);
                pose_row = int'(b.pose_y);
                h = int'(b.heading_deg);
                if (h >= DEG_FULL) begin
                    h = h - DEG_FULL;
                end
                head_now = h;
            end
            lpom_pkg::MODE_MARK: begin
                s   = sine_of(head_now);
                c   = sine_of(head_now + DEG_QUARTER);
                col = MAP_N / 2 + scale_q14(px, c) + scale_q14(py, s) + pose_col;
                row = MAP_N / 2 + scale_q14(py, c) - scale_q14(px, s) - pose_row;
                if (on_map(col, row)) begin
                    n = int'(col) * MAP_N + int'(row);
                    if (!occ_cells.exists(n)) begin
                        marked_cells.push_back(n);
                    end
                    occ_cells[n] = 1'b1;
                    a.cell_bit   = 1'b1;
                    a.in_map     = 1'b1;
                end
            end
            lpom_pkg::MODE_READ: begin
                if (on_map(px, py)) begin
                    n          = px * MAP_N + py;
                    a.cell_bit = (occ_cells.exists(n) != 0);
                    a.in_map   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    function automatic t_dir_row mk_row(input logic [lpom_pkg::MODE_W-1:0] mode, input int pxs,
                                        input int pys, input int hd, input int ptx,
                                        input int pty, input bit typed, input bit eb,
                                        input bit ei);
        t_dir_row r;
        r.beat.mode        = mode;
        r.beat.pose_x      = lpom_pkg::POSE_W'(pxs);
        r.beat.pose_y      = lpom_pkg::POSE_W'(pys);
        r.beat.heading_deg = lpom_pkg::HEAD_W'(hd);
        r.beat.point_x     = lpom_pkg::POINT_W'(ptx);
        r.beat.point_y     = lpom_pkg::POINT_W'(pty);
        r.typed            = typed;
        r.answer.cell_bit  = eb;
        r.answer.in_map    = ei;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int    r;
        int    n;
        b.mode        = lpom_pkg::MODE_W'($urandom);
        b.pose_x      = lpom_pkg::POSE_W'($urandom);
        b.pose_y      = lpom_pkg::POSE_W'($urandom);
        b.heading_deg = lpom_pkg::HEAD_W'($urandom);
        b.point_x     = lpom_pkg::POINT_W'($urandom);
        b.point_y     = lpom_pkg::POINT_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 22) begin
            b.mode = lpom_pkg::MODE_POSE;
            if ($urandom_range(0, 9) < 6) begin
                b.pose_x = lpom_pkg::POSE_W'($urandom_range(0, 128) - 64);
                b.pose_y = lpom_pkg::POSE_W'($urandom_range(0, 128) - 64);
            end
            b.heading_deg = lpom_pkg::HEAD_W'($urandom_range(0, 511));
        end else if (r < 67) begin
            b.mode = lpom_pkg::MODE_MARK;
            if ($urandom_range(0, 9) < 7) begin
                b.point_x = lpom_pkg::POINT_W'($urandom_range(0, 800) - 400);
                b.point_y = lpom_pkg::POINT_W'($urandom_range(0, 800) - 400);
            end
        end else if (r < 95) begin
            b.mode = lpom_pkg::MODE_READ;
            r = $urandom_range(0, 9);
            if (r < 6 && marked_cells.size() > 0) begin
                n         = marked_cells[$urandom_range(0, marked_cells.size() - 1)];
                b.point_x = lpom_pkg::POINT_W'(n / MAP_N);
                b.point_y = lpom_pkg::POINT_W'(n % MAP_N);
            end else if (r < 8) begin
                b.point_x = lpom_pkg::POINT_W'($urandom_range(0, MAP_N - 1));
                b.point_y = lpom_pkg::POINT_W'($urandom_range(0, MAP_N - 1));
            end
        end else begin
            b.mode = MODE_SPARE;
        end
        return b;
    endfunction

    task automatic send_beat(input t_beat b, input bit typed, input t_cell_answer typed_ans);
        t_cell_answer a;
        int           gap;
        i_valid       <= 1'b1;
        i_mode        <= b.mode;
        i_pose_x      <= b.pose_x;
        i_pose_y      <= b.pose_y;
        i_heading_deg <= b.heading_deg;
        i_point_x     <= b.point_x;
        i_point_y     <= b.point_y;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        a = occupancy_predict(b);
        cell_answers_q.push_back(typed ? typed_ans : a);
        beats_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: check, then choose ready for the next cycle
    initial begin
        t_cell_answer exp_ans;
        int           r;
        i_ready    <= 1'b0;
        stall_left  = 0;
        hold_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (cell_answers_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT) begin
                        $display("unexpected result beat: cell_bit %0b in_map %0b",
                                 o_cell_bit, o_in_map);
                    end
                end else begin
                    exp_ans = cell_answers_q.pop_front();
                    if (o_cell_bit !== exp_ans.cell_bit || o_in_map !== exp_ans.in_map) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT) begin
                            $display("mismatch: expected cell_bit %0b in_map %0b, got %0b %0b",
                                     exp_ans.cell_bit, exp_ans.in_map, o_cell_bit, o_in_map);
                        end
                    end
                end
            end
            if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !burst_phase) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    stall_left = $urandom_range(1, 3);
                end else if (r < 15) begin
                    stall_left = $urandom_range(4, 12);
                end else if (r < 16) begin
                    stall_left = $urandom_range(20, 60);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_cell_answer no_ans;
        t_beat        b;
        int           k;
        beats_sent    = 0;
        burst_phase   = 1'b0;
        pose_col      = 0;
        pose_row      = 0;
        head_now      = 0;
        no_ans.cell_bit = 1'b0;
        no_ans.in_map   = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_mode        <= lpom_pkg::MODE_POSE;
        i_pose_x      <= '0;
        i_pose_y      <= '0;
        i_heading_deg <= '0;
        i_point_x     <= '0;
        i_point_y     <= '0;

        // reads of a cleared map, at corner cells and past the low edges
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, 0, 0, 1, 0, 1));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, 1023, 1023, 1, 0, 1));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, -1, 5, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, 1023, -1, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, -1024, -1024, 1, 0, 0));
        // marks at zero heading, map center and corners
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 0, 0, 1, 1, 1));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, 512, 512, 1, 1, 1));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, 512, 513, 1, 0, 1));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 1023, 1023, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, -1024, -1024, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 511, -512, 1, 1, 1));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, 1023, 0, 1, 1, 1));
        // spare mode must leave the pose alone
        dir_tab.push_back(mk_row(MODE_SPARE, 511, 511, 511, 1023, 1023, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 3, 4, 0, 0, 0));
        // pose extremes, headings at and above a full turn, then quarter-turn headings
        dir_tab.push_back(mk_row(lpom_pkg::MODE_POSE, 511, -512, 511, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 100, 50, 0, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_POSE, -512, 511, 360, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 0, 0, 1, 1, 1));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_POSE, 0, 0, 90, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 100, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_POSE, 0, 0, 180, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 37, -45, 0, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_POSE, 0, 0, 270, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, -300, 200, 0, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_POSE, 3, -7, 359, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_MARK, 0, 0, 0, 1000, -3, 0, 0, 0));
        dir_tab.push_back(mk_row(lpom_pkg::MODE_READ, 0, 0, 0, 512, 412, 0, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            send_beat(dir_tab[k].beat, dir_tab[k].typed, dir_tab[k].answer);
        end

        for (k = 0; k < RANDOM_BEATS; k++) begin
            burst_phase = (k >= BURST_FIRST && k < BURST_LAST);
            b = random_beat();
            send_beat(b, 1'b0, no_ans);
        end
        burst_phase = 1'b0;
        i_valid <= 1'b0;

        while (cell_answers_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/lpom_pkg.sv
design/lpom_map_ram.sv
design/lpom_xform.sv
design/lidar_point_occupancy_marker_top.sv
design/lpom_checker.sv
tb/lidar_point_occupancy_marker_top_tb.sv
